FILE: hw/rtl/psgd_pkg.sv
package psgd_pkg;

    // Default geometry of the sample fields
    localparam int COORD_BITS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Configuration field widths
    localparam int TCFG_W     = 32;
    localparam int MIN_STEP_W = 17;
    localparam int REV_CNT_W  = 8;
    localparam int PATH_W     = 32;

    // Reset values of the configuration registers
    localparam logic [TCFG_W-1:0]     RST_MAX_SAMPLE_GAP    = 32'd100;
    localparam logic [TCFG_W-1:0]     RST_MAX_SEQUENCE_TIME = 32'd1000;
    localparam logic [MIN_STEP_W-1:0] RST_MIN_STEP_DISTANCE = 17'd8;
    localparam logic [REV_CNT_W-1:0]  RST_NEEDED_REVERSALS  = 8'd3;
    localparam logic [PATH_W-1:0]     RST_MIN_PATH_DISTANCE = 32'd300;
    localparam logic [TCFG_W-1:0]     RST_COOLDOWN_TIME     = 32'd1000;

    // Register index, taken from paddr word bits
    typedef enum logic [2:0] {
        REG_MAX_SAMPLE_GAP    = 3'd0,
        REG_MAX_SEQUENCE_TIME = 3'd1,
        REG_MIN_STEP_DISTANCE = 3'd2,
        REG_NEEDED_REVERSALS  = 3'd3,
        REG_MIN_PATH_DISTANCE = 3'd4,
        REG_COOLDOWN_TIME     = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [TCFG_W-1:0]     max_sample_gap;
        logic [TCFG_W-1:0]     max_sequence_time;
        logic [MIN_STEP_W-1:0] min_step_distance;
        logic [REV_CNT_W-1:0]  needed_reversals;
        logic [PATH_W-1:0]     min_path_distance;
        logic [TCFG_W-1:0]     cooldown_time;
    } cfg_t;

    // Status from the reversal engine to the control sequencer
    typedef struct packed {
        logic done;
        logic reversal;
    } rev_stat_t;

    // Control sequencer states
    typedef enum logic [2:0] {
        CS_IDLE,
        CS_CHECK,
        CS_STEP,
        CS_REV,
        CS_FINISH,
        CS_DONE
    } ctl_state_t;

    // Reversal engine states
    typedef enum logic [1:0] {
        RV_IDLE,
        RV_MUL,
        RV_DRAIN,
        RV_CMP
    } rev_state_t;

    // Multiply passes of the reversal test, in issue order
    typedef enum logic [3:0] {
        ST_DOT_X,
        ST_DOT_Y,
        ST_LP_X,
        ST_LP_Y,
        ST_LC_X,
        ST_LC_Y,
        ST_DD_HH,
        ST_DD_HL,
        ST_DD_LL,
        ST_LR_HH,
        ST_LR_HL,
        ST_LR_LH,
        ST_LR_LL
    } step_t;

endpackage

FILE: hw/rtl/psgd_cfg.sv
module psgd_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [psgd_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [psgd_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [psgd_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output psgd_pkg::cfg_t                      cfg
);
    import psgd_pkg::*;

    reg_idx_t idx;
    logic     wr_en;
    cfg_t     cfg_reg;

    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write the addressed register, mask to its width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_sample_gap    <= RST_MAX_SAMPLE_GAP;
            cfg_reg.max_sequence_time <= RST_MAX_SEQUENCE_TIME;
            cfg_reg.min_step_distance <= RST_MIN_STEP_DISTANCE;
            cfg_reg.needed_reversals  <= RST_NEEDED_REVERSALS;
            cfg_reg.min_path_distance <= RST_MIN_PATH_DISTANCE;
            cfg_reg.cooldown_time     <= RST_COOLDOWN_TIME;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MAX_SAMPLE_GAP:    cfg_reg.max_sample_gap    <= pwdata[TCFG_W-1:0];
                REG_MAX_SEQUENCE_TIME: cfg_reg.max_sequence_time <= pwdata[TCFG_W-1:0];
                REG_MIN_STEP_DISTANCE: cfg_reg.min_step_distance <= pwdata[MIN_STEP_W-1:0];
                REG_NEEDED_REVERSALS:  cfg_reg.needed_reversals  <= pwdata[REV_CNT_W-1:0];
                REG_MIN_PATH_DISTANCE: cfg_reg.min_path_distance <= pwdata[PATH_W-1:0];
                REG_COOLDOWN_TIME:     cfg_reg.cooldown_time     <= pwdata[TCFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_MAX_SAMPLE_GAP:    prdata = CFG_DATA_W'(cfg_reg.max_sample_gap);
            REG_MAX_SEQUENCE_TIME: prdata = CFG_DATA_W'(cfg_reg.max_sequence_time);
            REG_MIN_STEP_DISTANCE: prdata = CFG_DATA_W'(cfg_reg.min_step_distance);
            REG_NEEDED_REVERSALS:  prdata = CFG_DATA_W'(cfg_reg.needed_reversals);
            REG_MIN_PATH_DISTANCE: prdata = CFG_DATA_W'(cfg_reg.min_path_distance);
            REG_COOLDOWN_TIME:     prdata = CFG_DATA_W'(cfg_reg.cooldown_time);
            default:               prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/psgd_rev.sv
module psgd_rev #(
    parameter int COORD_BITS = psgd_pkg::COORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [COORD_BITS:0] px,
    input  logic signed [COORD_BITS:0] py,
    input  logic signed [COORD_BITS:0] cx,
    input  logic signed [COORD_BITS:0] cy,
    output psgd_pkg::rev_stat_t       stat
);
    import psgd_pkg::*;

    // K: step component width, M: multiplier operand width
    localparam int K  = COORD_BITS + 1;
    localparam int M  = K + 1;
    localparam int PW = 2 * M;
    localparam int DW = 2 * K + 1;
    localparam int AW = 4 * K + 2;

    rev_state_t state_reg, state_next;
    step_t      step_reg, tag_reg;
    logic       pvld_reg;

    logic signed [M-1:0]  a_op, b_op;
    logic signed [PW-1:0] prod_reg;
    logic signed [DW-1:0] dot_reg;
    logic [2*K-1:0]       lp_reg, lc_reg;
    logic [AW-1:0]        left_reg, right_reg;

    logic [DW-1:0]  dmag_full;
    logic [2*K-1:0] dmag;
    logic [AW-1:0]  prod_ext, acc_a, addend, acc_sum;

    // Magnitude of the dot product, split into halves
    assign dmag_full = dot_reg[DW-1] ? (~dot_reg + 1'b1) : dot_reg;
    assign dmag      = dmag_full[2*K-1:0];
    assign prod_ext  = {{(AW-PW){prod_reg[PW-1]}}, prod_reg};

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RV_IDLE;
            step_reg  <= ST_DOT_X;
            pvld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pvld_reg  <= (state_reg == RV_MUL);
            if (state_reg == RV_IDLE)
            begin
                step_reg <= ST_DOT_X;
            end
            else if (state_reg == RV_MUL && step_reg != ST_LR_LL)
            begin
                step_reg <= step_t'(step_reg + 4'd1);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        stat.done     = 1'b0;
        stat.reversal = 1'b0;
        unique case (state_reg)
            RV_IDLE:
            begin
                if (start)
                begin
                    state_next = RV_MUL;
                end
            end
            RV_MUL:
            begin
                if (step_reg == ST_LR_LL)
                begin
                    state_next = RV_DRAIN;
                end
            end
            RV_DRAIN:
            begin
                state_next = RV_CMP;
            end
            RV_CMP:
            begin
                stat.done     = 1'b1;
                stat.reversal = dot_reg[DW-1]
                                && ({left_reg[AW-3:0], 2'b00} >= right_reg);
                state_next    = RV_IDLE;
            end
            default:
            begin
                state_next = RV_IDLE;
            end
        endcase
    end

    // Select multiplier operands for this pass
    always_comb
    begin
        a_op = '0;
        b_op = '0;
        unique case (step_reg)
            ST_DOT_X: begin a_op = {px[K-1], px}; b_op = {cx[K-1], cx}; end
            ST_DOT_Y: begin a_op = {py[K-1], py}; b_op = {cy[K-1], cy}; end
            ST_LP_X:  begin a_op = {px[K-1], px}; b_op = {px[K-1], px}; end
            ST_LP_Y:  begin a_op = {py[K-1], py}; b_op = {py[K-1], py}; end
            ST_LC_X:  begin a_op = {cx[K-1], cx}; b_op = {cx[K-1], cx}; end
            ST_LC_Y:  begin a_op = {cy[K-1], cy}; b_op = {cy[K-1], cy}; end
            ST_DD_HH: begin a_op = {1'b0, dmag[2*K-1:K]}; b_op = {1'b0, dmag[2*K-1:K]}; end
            ST_DD_HL: begin a_op = {1'b0, dmag[2*K-1:K]}; b_op = {1'b0, dmag[K-1:0]}; end
            ST_DD_LL: begin a_op = {1'b0, dmag[K-1:0]}; b_op = {1'b0, dmag[K-1:0]}; end
            ST_LR_HH: begin a_op = {1'b0, lp_reg[2*K-1:K]}; b_op = {1'b0, lc_reg[2*K-1:K]}; end
            ST_LR_HL: begin a_op = {1'b0, lp_reg[2*K-1:K]}; b_op = {1'b0, lc_reg[K-1:0]}; end
            ST_LR_LH: begin a_op = {1'b0, lp_reg[K-1:0]}; b_op = {1'b0, lc_reg[2*K-1:K]}; end
            ST_LR_LL: begin a_op = {1'b0, lp_reg[K-1:0]}; b_op = {1'b0, lc_reg[K-1:0]}; end
            default:  begin a_op = '0; b_op = '0; end
        endcase
    end

    // Shared multiplier, registered
    always_ff @(posedge clk)
    begin
        prod_reg <= a_op * b_op;
        tag_reg  <= step_reg;
    end

    // Pick accumulation target and weight of the last product
    always_comb
    begin
        acc_a  = '0;
        addend = prod_ext;
        unique case (tag_reg) inside
            ST_DOT_X, ST_DOT_Y:
            begin
                acc_a = {{(AW-DW){dot_reg[DW-1]}}, dot_reg};
            end
            ST_LP_X, ST_LP_Y:
            begin
                acc_a = AW'(lp_reg);
            end
            ST_LC_X, ST_LC_Y:
            begin
                acc_a = AW'(lc_reg);
            end
            ST_DD_HH:
            begin
                acc_a  = left_reg;
                addend = prod_ext << (2 * K);
            end
            ST_DD_HL:
            begin
                acc_a  = left_reg;
                addend = prod_ext << (K + 1);
            end
            ST_DD_LL:
            begin
                acc_a = left_reg;
            end
            ST_LR_HH:
            begin
                acc_a  = right_reg;
                addend = prod_ext << (2 * K);
            end
            ST_LR_HL, ST_LR_LH:
            begin
                acc_a  = right_reg;
                addend = prod_ext << K;
            end
            ST_LR_LL:
            begin
                acc_a = right_reg;
            end
            default:
            begin
                acc_a = '0;
            end
        endcase
        acc_sum = acc_a + addend;
    end

    // Clear sums on start, accumulate each product from the multiplier register
    always_ff @(posedge clk)
    begin
        if (state_reg == RV_IDLE && start)
        begin
            dot_reg   <= '0;
            lp_reg    <= '0;
            lc_reg    <= '0;
            left_reg  <= '0;
            right_reg <= '0;
        end
        else if (pvld_reg)
        begin
            unique case (tag_reg) inside
                ST_DOT_X, ST_DOT_Y:           dot_reg   <= acc_sum[DW-1:0];
                ST_LP_X, ST_LP_Y:             lp_reg    <= acc_sum[2*K-1:0];
                ST_LC_X, ST_LC_Y:             lc_reg    <= acc_sum[2*K-1:0];
                ST_DD_HH, ST_DD_HL, ST_DD_LL: left_reg  <= acc_sum;
                ST_LR_HH, ST_LR_HL, ST_LR_LH,
                ST_LR_LL:                     right_reg <= acc_sum;
                default:
                begin
                end
            endcase
        end
    end

`ifndef SYNTH
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == RV_IDLE && start) |-> ##15 stat.done)
        else $error("reversal test did not finish on schedule");

    a_prod_source: assert property (@(posedge clk) disable iff (!rst_n)
        pvld_reg |-> $past(state_reg) == RV_MUL)
        else $error("product accumulated without a multiply pass");

    a_drain_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == RV_DRAIN) |-> (tag_reg == ST_LR_LL))
        else $error("drain cycle without the last product in flight");
`endif

endmodule

FILE: hw/rtl/pointer_shake_gesture_detector.sv
// Shake gesture detector for timestamped pointer samples. Each accepted
// sample gives exactly one result item (shake=1 when it completes a gesture).
// A sample passes CHECK and DONE if it opens a new sequence, adds STEP if
// its step is below min_step_distance, also FINISH for the first kept step
// of a sequence and also REV for a later kept step: the angle test runs
// thirteen passes through one shared multiplier plus a drain and a compare
// cycle. in_stall is high while a sample is in work; a finished result waits
// in the output register while the next sample is taken. Registers sit at
// byte address 4*i and may be written only while no sample is in work.
module pointer_shake_gesture_detector #(
    parameter int COORD_BITS = psgd_pkg::COORD_BITS_DEF,
    parameter int TIME_BITS  = psgd_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [COORD_BITS-1:0]     pos_x,
    input  logic signed [COORD_BITS-1:0]     pos_y,
    input  logic [TIME_BITS-1:0]             stamp,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             shake,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [psgd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [psgd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [psgd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import psgd_pkg::*;

    localparam int K       = COORD_BITS + 1;
    localparam int DSTW    = (COORD_BITS + 1 > MIN_STEP_W) ? COORD_BITS + 1 : MIN_STEP_W;
    localparam int CMPW    = (TIME_BITS > TCFG_W) ? TIME_BITS : TCFG_W;
    localparam int CEW     = CMPW + 1;
    localparam int PATH_XW = PATH_W + 1;

    cfg_t       cfg;
    rev_stat_t  rev_stat;
    ctl_state_t state_reg, state_next;

    // Sample under work
    logic signed [COORD_BITS-1:0] x_reg, y_reg;
    logic [TIME_BITS-1:0]         t_reg;
    logic signed [K-1:0]          dx_reg, dy_reg;
    logic                         rev_flag_reg;
    logic                         shake_pend_reg;

    // Gesture tracking state
    logic                         have_sample_reg;
    logic                         have_dir_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic signed [K-1:0]          prev_step_x_reg, prev_step_y_reg;
    logic [PATH_W-1:0]            path_sum_reg;
    logic [REV_CNT_W-1:0]         rev_count_reg;
    logic [CEW-1:0]               cooldown_end_reg;
    logic [TIME_BITS-1:0]         seq_start_reg, last_kept_reg;

    logic                         out_valid_reg, shake_reg;

    logic                 new_seq;
    logic [TIME_BITS-1:0] gap_diff, seq_diff;
    logic [K-1:0]         ax_full, ay_full;
    logic [COORD_BITS-1:0] ax, ay;
    logic [DSTW-1:0]      step_dist;
    logic                 short_step;
    logic [PATH_XW-1:0]   path_wide;
    logic [PATH_W-1:0]    path_sat;
    logic [REV_CNT_W-1:0] count_new;
    logic                 hit;
    logic                 out_free;
    logic                 rev_start;

    psgd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psgd_rev #(
        .COORD_BITS (COORD_BITS)
    ) u_rev (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rev_start),
        .px    (prev_step_x_reg),
        .py    (prev_step_y_reg),
        .cx    (dx_reg),
        .cy    (dy_reg),
        .stat  (rev_stat)
    );

    // Sequence restart conditions
    assign gap_diff = t_reg - last_kept_reg;
    assign seq_diff = t_reg - seq_start_reg;
    assign new_seq  = !have_sample_reg
                      || (CEW'(t_reg) < cooldown_end_reg)
                      || (t_reg < last_kept_reg)
                      || (CMPW'(gap_diff) > CMPW'(cfg.max_sample_gap))
                      || (CMPW'(seq_diff) > CMPW'(cfg.max_sequence_time));

    // Octagonal step distance
    assign ax_full = dx_reg[K-1] ? (~dx_reg + 1'b1) : dx_reg;
    assign ay_full = dy_reg[K-1] ? (~dy_reg + 1'b1) : dy_reg;
    assign ax      = ax_full[COORD_BITS-1:0];
    assign ay      = ay_full[COORD_BITS-1:0];
    assign step_dist = (ax > ay) ? (DSTW'(ax) + DSTW'(ay >> 1))
                                 : (DSTW'(ay) + DSTW'(ax >> 1));
    assign short_step = step_dist < DSTW'(cfg.min_step_distance);

    // Saturating path sum
    assign path_wide = {1'b0, path_sum_reg} + PATH_XW'(step_dist);
    assign path_sat  = path_wide[PATH_W] ? '1 : path_wide[PATH_W-1:0];

    // Saturating reversal count and shake decision
    assign count_new = (rev_flag_reg && rev_count_reg != '1) ? rev_count_reg + 1'b1
                                                              : rev_count_reg;
    assign hit = (count_new >= cfg.needed_reversals)
                 && (path_sum_reg >= cfg.min_path_distance);

    assign out_free  = !out_valid_reg || !out_stall;
    assign rev_start = (state_reg == CS_STEP) && !short_step && have_dir_reg;

    assign in_stall  = (state_reg != CS_IDLE);
    assign out_valid = out_valid_reg;
    assign shake     = shake_reg;

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = CS_CHECK;
                end
            end
            CS_CHECK:
            begin
                state_next = new_seq ? CS_DONE : CS_STEP;
            end
            CS_STEP:
            begin
                if (short_step)
                begin
                    state_next = CS_DONE;
                end
                else if (have_dir_reg)
                begin
                    state_next = CS_REV;
                end
                else
                begin
                    state_next = CS_FINISH;
                end
            end
            CS_REV:
            begin
                if (rev_stat.done)
                begin
                    state_next = CS_FINISH;
                end
            end
            CS_FINISH:
            begin
                state_next = CS_DONE;
            end
            CS_DONE:
            begin
                if (out_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // Capture the item and its step
    always_ff @(posedge clk)
    begin
        if (state_reg == CS_IDLE && in_valid)
        begin
            x_reg <= pos_x;
            y_reg <= pos_y;
            t_reg <= stamp;
        end
        if (state_reg == CS_CHECK)
        begin
            dx_reg <= {x_reg[COORD_BITS-1], x_reg} - {prev_x_reg[COORD_BITS-1], prev_x_reg};
            dy_reg <= {y_reg[COORD_BITS-1], y_reg} - {prev_y_reg[COORD_BITS-1], prev_y_reg};
            shake_pend_reg <= 1'b0;
        end
        if (state_reg == CS_STEP)
        begin
            rev_flag_reg <= 1'b0;
        end
        else if (state_reg == CS_REV && rev_stat.done)
        begin
            rev_flag_reg <= rev_stat.reversal;
        end
        if (state_reg == CS_FINISH)
        begin
            shake_pend_reg <= hit;
        end
    end

    // Update gesture tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_sample_reg  <= 1'b0;
            have_dir_reg     <= 1'b0;
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
            prev_step_x_reg  <= '0;
            prev_step_y_reg  <= '0;
            path_sum_reg     <= '0;
            rev_count_reg    <= '0;
            cooldown_end_reg <= '0;
            seq_start_reg    <= '0;
            last_kept_reg    <= '0;
        end
        else
        begin
            if ((state_reg == CS_CHECK && new_seq) || (state_reg == CS_FINISH && hit))
            begin
                have_sample_reg <= 1'b1;
                have_dir_reg    <= 1'b0;
                prev_x_reg      <= x_reg;
                prev_y_reg      <= y_reg;
                prev_step_x_reg <= '0;
                prev_step_y_reg <= '0;
                path_sum_reg    <= '0;
                rev_count_reg   <= '0;
                seq_start_reg   <= t_reg;
                last_kept_reg   <= t_reg;
                if (state_reg == CS_FINISH)
                begin
                    cooldown_end_reg <= CEW'(t_reg) + CEW'(cfg.cooldown_time);
                end
            end
            else if (state_reg == CS_STEP && !short_step)
            begin
                path_sum_reg <= path_sat;
            end
            else if (state_reg == CS_FINISH)
            begin
                have_dir_reg    <= 1'b1;
                rev_count_reg   <= count_new;
                prev_x_reg      <= x_reg;
                prev_y_reg      <= y_reg;
                prev_step_x_reg <= dx_reg;
                prev_step_y_reg <= dy_reg;
                last_kept_reg   <= t_reg;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == CS_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == CS_DONE && out_free)
        begin
            shake_reg <= shake_pend_reg;
        end
    end

`ifndef SYNTH
    a_shake_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_DONE && shake_pend_reg)
        |-> (path_sum_reg == '0 && rev_count_reg == '0 && !have_dir_reg))
        else $error("shake reported without a sequence restart");

    a_rev_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        rev_stat.done |-> state_reg == CS_REV)
        else $error("reversal result arrived while sequencer was not waiting");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(shake_reg)))
        else $error("result item changed while stalled");
`endif

endmodule

FILE: tb/tb_pointer_shake_gesture_detector.sv
`timescale 1ns / 100ps

module tb_pointer_shake_gesture_detector;
    import psgd_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int TW = TIME_BITS_DEF;
    localparam int COORD_LO = -(1 << (CW - 1));
    localparam int COORD_HI = (1 << (CW - 1)) - 1;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD = 400;
    localparam int BATCH_ITEMS = 55;
    localparam int LONG_BATCH_ITEMS = 300;
    localparam int TAIL_ITEMS = 30;
    localparam int SETTINGS_COUNT = 9;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [TW-1:0]        stamp;
    } sample_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic signed [CW-1:0]  pos_x = '0;
    logic signed [CW-1:0]  pos_y = '0;
    logic [TW-1:0]         stamp = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  shake;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    pointer_shake_gesture_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .stamp     (stamp),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .shake     (shake),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 clk = ~clk;

    // Register copy seen by the gesture tracker
    cfg_t live_cfg = '{RST_MAX_SAMPLE_GAP, RST_MAX_SEQUENCE_TIME, RST_MIN_STEP_DISTANCE,
                       RST_NEEDED_REVERSALS, RST_MIN_PATH_DISTANCE, RST_COOLDOWN_TIME};

    // Gesture tracker state
    bit              trk_have = 1'b0;
    bit              trk_dir = 1'b0;
    longint          trk_x = 0;
    longint          trk_y = 0;
    longint          trk_dx = 0;
    longint          trk_dy = 0;
    longint unsigned trk_path = 0;
    int unsigned     trk_revs = 0;
    longint unsigned trk_cool_end = 0;
    longint unsigned trk_seq_start = 0;
    longint unsigned trk_kept_at = 0;

    sample_t pending_samples[$];
    bit      expected_shake[$];
    int      samples_issued = 0;
    int      samples_taken = 0;
    int      errors = 0;
    int      idle_run = 0;
    logic    in_fire = 1'b0;

    int          send_idle_pct = 11;
    int          recv_idle_pct = 78;
    bit          long_hold_due = 1'b0;
    bit          long_hold_done = 1'b0;
    int          hold_left = 0;
    bit [TW-1:0] clock_ms = '0;
    int          last_x = 0;
    int          last_y = 0;
    int          burst_dt_cap = 60;

    function automatic void open_sequence(input longint x, input longint y,
                                          input longint unsigned t);
        trk_have = 1'b1;
        trk_dir = 1'b0;
        trk_x = x;
        trk_y = y;
        trk_dx = 0;
        trk_dy = 0;
        trk_path = 0;
        trk_revs = 0;
        trk_seq_start = t;
        trk_kept_at = t;
    endfunction

    // Advance the tracker by one sample; return the shake flag it yields
    function automatic bit track_gesture(input sample_t s);
        longint          x, y, dx, dy, dot;
        longint unsigned t, ax, ay, step_dist, mag_dot, len_prev, len_cur;
        logic [127:0]    lhs, rhs;
        bit              turned;
        x = s.x;
        y = s.y;
        t = s.stamp;
        if (!trk_have || t < trk_cool_end || t < trk_kept_at
            || t - trk_kept_at > live_cfg.max_sample_gap
            || t - trk_seq_start > live_cfg.max_sequence_time) begin
            open_sequence(x, y, t);
            return 1'b0;
        end

        // Octagonal step length
        dx = x - trk_x;
        dy = y - trk_y;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        step_dist = (ax > ay) ? ax + (ay >> 1) : ay + (ax >> 1);
        if (step_dist < live_cfg.min_step_distance)
            return 1'b0;

        trk_path = trk_path + step_dist;
        if (trk_path > 64'hFFFF_FFFF)
            trk_path = 64'hFFFF_FFFF;

        // Reversal: obtuse and 4*dot^2 >= |prev|^2 * |cur|^2, exact
        turned = 1'b0;
        if (trk_dir) begin
            dot = trk_dx * dx + trk_dy * dy;
            if (dot < 0) begin
                mag_dot = -dot;
                len_prev = trk_dx * trk_dx + trk_dy * trk_dy;
                len_cur = dx * dx + dy * dy;
                lhs = 128'(mag_dot) * 128'(mag_dot) * 128'd4;
                rhs = 128'(len_prev) * 128'(len_cur);
                turned = (lhs >= rhs);
            end
        end
        if (turned && trk_revs < 255)
            trk_revs = trk_revs + 1;

        trk_x = x;
        trk_y = y;
        trk_dx = dx;
        trk_dy = dy;
        trk_kept_at = t;
        trk_dir = 1'b1;

        if (trk_revs < live_cfg.needed_reversals || trk_path < live_cfg.min_path_distance)
            return 1'b0;
        trk_cool_end = t + live_cfg.cooldown_time;
        open_sequence(x, y, t);
        return 1'b1;
    endfunction

    // Sample driver: present the next pending item once the last one is taken
    always @(negedge clk)
    begin : drive_samples
        sample_t nxt;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_samples.pop_front();
                pos_x <= nxt.x;
                pos_y <= nxt.y;
                stamp <= nxt.stamp;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver: random stall, with one long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (long_hold_due && !long_hold_done)
        begin
            out_stall <= 1'b1;
            hold_left <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Monitor: check results, predict on accepted items, watch for a hang
    always @(posedge clk)
    begin
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_shake.size() == 0)
                begin
                    $display("%0t: shake result with nothing pending, got %0b", $time, shake);
                    errors++;
                end
                else if (shake !== expected_shake[0])
                begin
                    $display("%0t: shake mismatch, expected %0b, got %0b",
                             $time, expected_shake[0], shake);
                    errors++;
                    void'(expected_shake.pop_front());
                end
                else
                    void'(expected_shake.pop_front());
            end
            if (in_valid && !in_stall)
            begin
                expected_shake.push_back(track_gesture('{pos_x, pos_y, stamp}));
                samples_taken++;
            end

            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                idle_run <= 0;
            else
                idle_run <= idle_run + 1;
            if (idle_run >= STALL_LIMIT)
            begin
                $display("pointer_shake_gesture_detector regression: fail");
                $finish;
            end
        end
    end

    function automatic int clamp_coord(input int v);
        if (v < COORD_LO)
            return COORD_LO;
        if (v > COORD_HI)
            return COORD_HI;
        return v;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range((1 << CW) - 1)) + COORD_LO;
    endfunction

    function automatic void queue_sample(input int x, input int y, input bit [TW-1:0] t);
        sample_t s;
        s.x = CW'(clamp_coord(x));
        s.y = CW'(clamp_coord(y));
        s.stamp = t;
        pending_samples.push_back(s);
        samples_issued++;
        last_x = s.x;
        last_y = s.y;
    endfunction

    // Time between samples: mostly within the allowed gap, sometimes past it
    function automatic bit [TW-1:0] step_dt(input bit stale);
        longint unsigned gap;
        gap = live_cfg.max_sample_gap;
        if (stale && gap < 100000)
            return TW'(gap + 1 + $urandom_range(5));
        if (gap == 0 || $urandom_range(19) == 0)
            return '0;
        return $urandom_range(32'((gap < burst_dt_cap) ? gap : burst_dt_cap), 1);
    endfunction

    // Back-and-forth motion between two jittered end points, then a pause
    task automatic queue_burst(input int n);
        int ax, ay, bx, by, span, ox, oy, jit, i;
        longint unsigned cd;
        case ($urandom_range(2))
            0: span = 16;
            1: span = 600;
            default: span = (1 << CW) - 1;
        endcase
        ax = rand_coord();
        ay = rand_coord();
        ox = int'($urandom_range(2 * span)) - span;
        oy = int'($urandom_range(2 * span)) - span;
        bx = (ax + ox > COORD_HI || ax + ox < COORD_LO) ? ax - ox : ax + ox;
        by = (ay + oy > COORD_HI || ay + oy < COORD_LO) ? ay - oy : ay + oy;
        jit = $urandom_range(span / 2 + 2);
        for (i = 0; i < n; i++)
        begin
            clock_ms = clock_ms + step_dt($urandom_range(39) == 0);
            queue_sample(((i % 2) ? bx : ax) + int'($urandom_range(2 * jit)) - jit,
                         ((i % 2) ? by : ay) + int'($urandom_range(2 * jit)) - jit,
                         clock_ms);
        end
        cd = live_cfg.cooldown_time;
        case ($urandom_range(2))
            0: clock_ms = clock_ms + $urandom_range(200);
            1: clock_ms = clock_ms + ((cd < 5000) ? TW'(cd + $urandom_range(30))
                                                  : $urandom_range(200));
            default: clock_ms = clock_ms + ((cd < 5000) ? $urandom_range(32'(cd)) : 0);
        endcase
    endtask

    // Stray items: random everything, tiny steps, time going back, stale gaps
    task automatic queue_noise();
        case ($urandom_range(3))
            0: queue_sample(rand_coord(), rand_coord(), $urandom());
            1: queue_sample(last_x + int'($urandom_range(6)) - 3,
                            last_y + int'($urandom_range(6)) - 3, clock_ms);
            2: if (clock_ms > 60)
                   queue_sample(rand_coord(), rand_coord(), clock_ms - $urandom_range(60, 1));
            default:
            begin
                clock_ms = clock_ms + step_dt(1'b1);
                queue_sample(last_x + 40, last_y - 40, clock_ms);
            end
        endcase
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_MAX_SAMPLE_GAP:    live_cfg.max_sample_gap = val;
            REG_MAX_SEQUENCE_TIME: live_cfg.max_sequence_time = val;
            REG_MIN_STEP_DISTANCE: live_cfg.min_step_distance = val[MIN_STEP_W-1:0];
            REG_NEEDED_REVERSALS:  live_cfg.needed_reversals = val[REV_CNT_W-1:0];
            REG_MIN_PATH_DISTANCE: live_cfg.min_path_distance = val;
            REG_COOLDOWN_TIME:     live_cfg.cooldown_time = val;
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apply_setting(input int b);
        cfg_t c;
        case (b)
            1: c = '{32'd0, 32'hFFFF_FFFF, 17'd0, 8'd0, 32'd0, 32'd0};
            2: c = '{32'hFFFF_FFFF, 32'd5000, 17'd98302, 8'd1, 32'hFFFF_FFFF, 32'd50};
            3: c = '{32'd40, 32'd400, 17'd20, 8'd2, 32'd200, 32'd100};
            4: c = '{32'd1000, 32'd0, 17'd1, 8'd4, 32'd1000, 32'd0};
            5: c = '{32'd200, 32'hFFFF_FFFF, 17'd5, 8'd255, 32'd20000, 32'd10};
            6: c = '{32'd60, 32'd800, 17'd12, 8'd3, 32'd500, 32'd300};
            7: c = '{32'd150, 32'd2000, 17'd8, 8'd5, 32'd2000, 32'd2000};
            8: c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd8, 8'd1, 32'd100, 32'hFFFF_FFFF};
            default: c = '{32'd100, 32'd1000, 17'd8, 8'd3, 32'd300, 32'd1000};
        endcase
        write_reg(REG_MAX_SAMPLE_GAP, c.max_sample_gap);
        write_reg(REG_MAX_SEQUENCE_TIME, c.max_sequence_time);
        write_reg(REG_MIN_STEP_DISTANCE, CFG_DATA_W'(c.min_step_distance));
        write_reg(REG_NEEDED_REVERSALS, CFG_DATA_W'(c.needed_reversals));
        write_reg(REG_MIN_PATH_DISTANCE, c.min_path_distance);
        write_reg(REG_COOLDOWN_TIME, c.cooldown_time);
    endtask

    // Wait until every issued item is taken and every result has come back
    task automatic wait_drained();
        do @(negedge clk); while (samples_taken != samples_issued || expected_shake.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        int b, goal, n;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: a plain shake, cooldown, extremes, small step, angle edges
        queue_sample(0, 0, 0);
        queue_sample(100, 0, 10);
        queue_sample(0, 0, 20);
        queue_sample(100, 0, 30);
        queue_sample(0, 0, 40);
        queue_sample(100, 0, 50);
        queue_sample(COORD_LO, COORD_LO, 1100);
        queue_sample(COORD_HI, COORD_HI, 1110);
        queue_sample(COORD_LO, COORD_LO, 1120);
        queue_sample(COORD_LO + 3, COORD_LO + 4, 1130);
        queue_sample(0, 0, 1300);
        queue_sample(10, 0, 1310);
        queue_sample(0, 17, 1320);
        queue_sample(-10, 35, 1330);
        queue_sample(0, 35, 1340);
        queue_sample(0, 45, 1350);
        queue_sample(50, 45, 1200);
        queue_sample(60, 45, 1210);
        clock_ms = 1500;
        wait_drained();

        // Random: bursts of back-and-forth motion mixed with stray items
        for (b = 0; b < SETTINGS_COUNT; b++)
        begin
            send_idle_pct = (b < 3) ? 11 : (b < 6) ? 78 : 0;
            recv_idle_pct = (b < 3) ? 78 : (b < 6) ? 11 : 0;
            burst_dt_cap = (b == 5) ? 10 : 60;
            apply_setting(b);
            if (b == SETTINGS_COUNT - 1)
                clock_ms = 32'hFFFF_F000;
            goal = samples_issued + ((b == 5) ? LONG_BATCH_ITEMS :
                                     (b == SETTINGS_COUNT - 1) ? TAIL_ITEMS : BATCH_ITEMS);
            if (b == 6)
                long_hold_due = 1'b1;
            while (samples_issued < goal)
            begin
                if ($urandom_range(99) < 75)
                begin
                    n = live_cfg.needed_reversals + 2 + $urandom_range(3);
                    if (n > goal - samples_issued + 1)
                        n = goal - samples_issued + 1;
                    queue_burst(n);
                end
                else
                    queue_noise();
            end
            if (b == SETTINGS_COUNT - 1)
                queue_sample(0, 0, 32'hFFFF_FFFF);
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("pointer_shake_gesture_detector regression: pass");
        else
            $display("pointer_shake_gesture_detector regression: fail");
        $finish;
    end

endmodule
